// ===== sv/format_string_integer_printer_defines.svh =====
// Assertion macros for the format printer checker.
`ifndef FORMAT_STRING_INTEGER_PRINTER_DEFINES_SVH
`define FORMAT_STRING_INTEGER_PRINTER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define FPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds across reset.
`define FPI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/fpi_pkg.sv =====
// Types, constants and helpers for the format string integer printer.
package fpi_pkg;

    localparam int ARG_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 10;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;
    localparam int MAX_DIGITS  = 10;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int RECIP_SHIFT = 35;

    localparam logic [ARG_W-1:0]  RECIP10      = 32'hCCCC_CCCD;
    localparam logic [CFG_W-1:0]  MAXLEN_RESET = 11'd256;
    localparam logic [CFG_W-1:0]  MAXLEN_TOP   = 11'd1024;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        K_CHAR,
        K_DEC,
        K_HEX,
        K_END
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic [ARG_W-1:0]  arg;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_SIGN,
        B_DIGIT,
        B_CHAR,
        B_TERM
    } back_state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] base;
        base = (d < 4'd10) ? 8'h30 : 8'h57;
        return base + {4'h0, d};
    endfunction

endpackage

// ===== sv/format_string_integer_printer.sv =====
// Top level of the format string integer printer (%d and %x conversions).
// A plain or end item passes through the queue and the CHAR or TERM state to the output register.
// A conversion runs MUL, then DIV once per digit, then SIGN for a negative %d, then DIGIT per char.
// The engine takes a queued item only in its IDLE state, one item at a time; a stalled output holds it.
// Reset: synchronous active-low aresetn clears the queue, armed percent, count; max_length=256.
module format_string_integer_printer
    import fpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // max_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [7:0] fmt_char, [39:8] arg_value
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [7:0] out_char
    output logic                 m_tuser,    // [0] is_terminator
    output logic                 m_tlast
);

    logic q_full;
    logic q_push;
    cmd_t q_in_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_out_cmd;

    assign cfg_ready = 1'b1;

    fpi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    fpi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_push),
        .in_cmd    (q_in_cmd),
        .full      (q_full),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_out_cmd)
    );

    fpi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_out_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/fpi_queue.sv =====
// Short command queue between the classifier and the output engine.
module fpi_queue
    import fpi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic full,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !full;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== sv/fpi_front.sv =====
// Input classifier: tracks the armed percent and queues printable work.
module fpi_front
    import fpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic              pend_reg;
    logic              pend_next;
    logic              accept;
    logic [CHAR_W-1:0] ch;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign ch       = s_tdata[CHAR_W-1:0];

    always_comb begin
        pend_next  = pend_reg;
        q_push     = 1'b0;
        q_cmd.kind = K_CHAR;
        q_cmd.ch   = ch;
        q_cmd.arg  = s_tdata[CHAR_W +: ARG_W];
        if (accept) begin
            priority if (s_tlast) begin
                q_push     = 1'b1;
                q_cmd.kind = K_END;
                pend_next  = 1'b0;
            end else if (pend_reg && ch == CH_D) begin
                q_push     = 1'b1;
                q_cmd.kind = K_DEC;
                pend_next  = 1'b0;
            end else if (pend_reg && ch == CH_X) begin
                q_push     = 1'b1;
                q_cmd.kind = K_HEX;
                pend_next  = 1'b0;
            end else if (ch == CH_PERCENT) begin
                pend_next  = 1'b1;
            end else begin
                q_push     = 1'b1;
                q_cmd.kind = K_CHAR;
                pend_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== sv/fpi_back.sv =====
// Output engine: digit generation, length limit and result register.
module fpi_back
    import fpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cmd_t                 q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    back_state_t          state_reg, state_next;
    logic [CFG_W-1:0]     maxlen_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ARG_W-1:0]     cur_reg, cur_next;
    logic [2*ARG_W-1:0]   prod_reg, prod_next;
    logic                 dec_reg, dec_next;
    logic                 neg_reg, neg_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [3:0]           dig_reg [MAX_DIGITS];
    logic [DIG_IDX_W-1:0] ndig_reg, ndig_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 dig_we;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_term_reg, out_term_next;
    logic                 out_last_reg, out_last_next;

    logic [CNT_W-1:0]     limit;
    logic [CFG_W-1:0]     maxlen_m1;
    logic                 full;
    logic                 at_lim;
    logic                 out_free;
    logic                 pop;
    logic                 arg_neg;
    logic [ARG_W-1:0]     q_val;
    logic [ARG_W-1:0]     q10;
    logic [3:0]           rem;
    logic [ARG_W-1:0]     mul_in;

    assign maxlen_m1 = maxlen_reg - 1'b1;
    always_comb begin
        priority if (maxlen_reg == '0) begin
            limit = '0;
        end else if (maxlen_reg > MAXLEN_TOP) begin
            limit = '1;
        end else begin
            limit = maxlen_m1[CNT_W-1:0];
        end
    end

    assign full     = (cnt_reg >= limit);
    assign at_lim   = (({1'b0, cnt_reg} + 1'b1) >= {1'b0, limit});
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == B_IDLE);
    assign pop      = q_valid && q_ready;
    assign arg_neg  = (q_cmd.kind == K_DEC) && q_cmd.arg[ARG_W-1];

    assign q_val  = dec_reg ? ARG_W'(prod_reg[2*ARG_W-1:RECIP_SHIFT]) : (cur_reg >> 4);
    assign q10    = (q_val << 3) + (q_val << 1);
    assign rem    = dec_reg ? (cur_reg[3:0] - q10[3:0]) : cur_reg[3:0];
    assign mul_in = (state_reg == B_MUL) ? cur_reg : q_val;
    assign prod_next = {{ARG_W{1'b0}}, mul_in} * {{ARG_W{1'b0}}, RECIP10};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.kind)
                        K_CHAR: state_next = B_CHAR;
                        K_END:  state_next = B_TERM;
                        K_DEC:  state_next = B_MUL;
                        K_HEX:  state_next = B_MUL;
                    endcase
                end
            end
            B_MUL: state_next = B_DIV;
            B_DIV: begin
                if (q_val == '0) begin
                    state_next = neg_reg ? B_SIGN : B_DIGIT;
                end
            end
            B_SIGN: begin
                if (full) begin
                    state_next = B_IDLE;
                end else if (out_free) begin
                    state_next = B_DIGIT;
                end
            end
            B_DIGIT: begin
                if (full || (out_free && idx_reg == '0)) begin
                    state_next = B_IDLE;
                end
            end
            B_CHAR: begin
                if (full || out_free) begin
                    state_next = B_IDLE;
                end
            end
            B_TERM: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        dec_next       = dec_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        ndig_next      = ndig_reg;
        idx_next       = idx_reg;
        dig_we         = 1'b0;
        out_char_next  = out_char_reg;
        out_term_next  = out_term_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    char_next = q_cmd.ch;
                    dec_next  = (q_cmd.kind == K_DEC);
                    neg_next  = arg_neg;
                    cur_next  = arg_neg ? (~q_cmd.arg + 1'b1) : q_cmd.arg;
                end
            end
            B_MUL: begin
                ndig_next = '0;
            end
            B_DIV: begin
                dig_we    = 1'b1;
                cur_next  = q_val;
                ndig_next = ndig_reg + 1'b1;
                idx_next  = ndig_reg;
            end
            B_SIGN: begin
                if (!full && out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    out_term_next  = 1'b0;
                    out_last_next  = at_lim;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            B_DIGIT: begin
                if (!full && out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = hex_char(dig_reg[idx_reg]);
                    out_term_next  = 1'b0;
                    out_last_next  = at_lim || (idx_reg == '0);
                    cnt_next       = cnt_reg + 1'b1;
                    idx_next       = idx_reg - 1'b1;
                end
            end
            B_CHAR: begin
                if (!full && out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = char_reg;
                    out_term_next  = 1'b0;
                    out_last_next  = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            B_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NUL;
                    out_term_next  = 1'b1;
                    out_last_next  = 1'b1;
                    cnt_next       = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            maxlen_reg    <= MAXLEN_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                maxlen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        dec_reg      <= dec_next;
        neg_reg      <= neg_next;
        char_reg     <= char_next;
        ndig_reg     <= ndig_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_term_reg <= out_term_next;
        out_last_reg <= out_last_next;
        if (dig_we) begin
            dig_reg[ndig_reg] <= rem;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_term_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/fpi_checker.sv =====
// Port-level checks for the format string integer printer, bound to the top level.
`include "format_string_integer_printer_defines.svh"

module fpi_checker
    import fpi_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_W-1:0]     cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    `FPI_ASSERT(a_term_last, m_tvalid && m_tuser |-> m_tlast, "terminator without last")
    `FPI_ASSERT(a_term_nul, m_tvalid && m_tuser |-> m_tdata == CH_NUL, "terminator not NUL")
    `FPI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")
    `FPI_ASSERT_RST(a_rst_idle, !aresetn |=> !m_tvalid, "item valid after reset")

endmodule

bind format_string_integer_printer fpi_checker u_fpi_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for format_string_integer_printer: stream stimulus, predicted output chars.
`timescale 1ns / 100ps

module tb
    import fpi_pkg::*;
();

    localparam int          IDLE_PCT      = 38;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          RANDOM_ITEMS  = 370;
    localparam int          LONG_BODY     = 230;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [7:0]  DIGIT_ZERO    = 8'h30;
    localparam logic [7:0]  LETTER_A      = 8'h61;
    localparam logic [31:0] INT_MIN       = 32'h8000_0000;
    localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              term;
        logic              is_last;
    } printed_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    printed_t         expected_chars[$];
    logic [CFG_W-1:0] max_len     = MAXLEN_RESET;
    logic             pct_armed   = 1'b0;
    logic [CNT_W-1:0] out_count   = '0;
    int               mismatch_count = 0;
    int               items_sent     = 0;
    bit               quiet          = 1'b0;

    format_string_integer_printer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),    // max_length
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] fmt_char, [39:8] arg_value
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] out_char
        .m_tuser   (m_tuser),     // [0] is_terminator
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned char_cap();
        int unsigned m;
        m = 32'(max_len);
        if (m < 1) m = 1;
        if (m > MAXLEN_TOP) m = 32'(MAXLEN_TOP);
        return m - 1;
    endfunction

    function automatic void push_char(input logic [CHAR_W-1:0] c);
        if (out_count < char_cap()) begin
            expected_chars.push_back('{ch: c, term: 1'b0, is_last: 1'b0});
            out_count = out_count + 1'b1;
        end
    endfunction

    function automatic void push_number(input logic [ARG_W-1:0] v, input bit dec);
        logic [CHAR_W-1:0] digs[$];
        logic [ARG_W-1:0]  base;
        logic [3:0]        d;
        base = dec ? 32'd10 : 32'd16;
        if (dec && v[ARG_W-1]) begin
            push_char(CH_MINUS);
            v = -v;
        end
        do begin
            d = 4'(v % base);
            digs.push_front(d < 4'd10 ? DIGIT_ZERO + {4'h0, d}
                                      : LETTER_A + {4'h0, d} - 8'd10);
            v = v / base;
        end while (v != '0);
        foreach (digs[i]) push_char(digs[i]);
    endfunction

    function automatic void format_item(input logic [CHAR_W-1:0] ch,
                                        input logic [ARG_W-1:0] arg, input bit fin);
        int n0;
        n0 = expected_chars.size();
        if (fin) begin
            expected_chars.push_back('{ch: CH_NUL, term: 1'b1, is_last: 1'b1});
            pct_armed = 1'b0;
            out_count = '0;
        end else if (pct_armed && (ch == CH_D || ch == CH_X)) begin
            pct_armed = 1'b0;
            push_number(arg, ch == CH_D);
        end else begin
            pct_armed = (ch == CH_PERCENT);
            if (!pct_armed) push_char(ch);
        end
        if (expected_chars.size() > n0) expected_chars[expected_chars.size() - 1].is_last = 1'b1;
    endfunction

    function automatic logic [ARG_W-1:0] rand_arg(input bit wide);
        if (wide) return $urandom;
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 99);
            2:       return -$urandom_range(0, 999);
            3:       return INT_MIN;
            4:       return INT_MAX;
            default: return $urandom_range(0, 1) ? '0 : '1;
        endcase
    endfunction

    always @(negedge aclk) m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge aclk) begin
        printed_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item: char %h term %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== m_tdata || want.term !== m_tuser
                        || want.is_last !== m_tlast) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch %0t: want %h/%b/%b got %h/%b/%b",
                                 $realtime, want.ch, want.term, want.is_last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg,
                             input bit fin);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {arg, ch};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        format_item(ch, arg, fin);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_length(input logic [CFG_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        max_len = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_string(input int body, input int conv_pct, input bit wide,
                              input bit hold_mid);
        int k;
        int pick;
        k = 0;
        while (k < body) begin
            if (hold_mid && k >= body / 2) begin
                wait_idle();
                hold_mid = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < conv_pct) begin
                send_item(CH_PERCENT, rand_arg(wide), 1'b0);
                send_item($urandom_range(0, 1) ? CH_D : CH_X, rand_arg(wide), 1'b0);
                k += 2;
            end else if (pick < conv_pct + 8) begin
                send_item(CH_PERCENT, rand_arg(wide), 1'b0);
                send_item(CHAR_W'($urandom_range(0, 255)), rand_arg(wide), 1'b0);
                k += 2;
            end else if (pick < conv_pct + 15) begin
                send_item(CHAR_W'($urandom_range(0, 255)), $urandom, 1'b0);
                k++;
            end else begin
                send_item(CHAR_W'($urandom_range(32, 126)), $urandom, 1'b0);
                k++;
            end
        end
        send_item(CHAR_W'($urandom_range(0, 255)), $urandom, 1'b1);
    endtask

    task automatic test_plain_chars();
        send_item("H", INT_MAX, 1'b0);
        send_item(CH_NUL, '0, 1'b0);
        send_item(8'hFF, '1, 1'b0);
        send_item(CH_PERCENT, INT_MIN, 1'b1);
    endtask

    task automatic test_conversions();
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, '0, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, INT_MIN, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, INT_MAX, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_X, '1, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_X, INT_MIN, 1'b0);
        send_item(CH_NUL, '0, 1'b1);
    endtask

    task automatic test_percent_cases();
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, -32'd5, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item("q", '1, 1'b0);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, '0, 1'b1);
    endtask

    task automatic test_length_limit();
        set_max_length(11'd5);
        send_item(CH_PERCENT, '0, 1'b0);
        send_item(CH_D, -32'd12345678, 1'b0);
        send_item(CH_X, '0, 1'b1);
        set_max_length(11'd0);
        send_item("a", '0, 1'b0);
        send_item("a", '0, 1'b1);
    endtask

    task automatic test_random_strings();
        int start;
        int phase;
        start = items_sent;
        phase = 0;
        set_max_length('1);
        run_string(LONG_BODY, 92, 1'b1, 1'b1);
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet = (phase >= 4 && phase < 10);
            if ($urandom_range(0, 99) < 40) begin
                case ($urandom_range(0, 6))
                    0:       set_max_length(11'd0);
                    1:       set_max_length(11'd1);
                    2:       set_max_length(11'd2);
                    3:       set_max_length(MAXLEN_TOP);
                    4:       set_max_length(CFG_W'($urandom_range(0, 2047)));
                    default: set_max_length(CFG_W'($urandom_range(2, 40)));
                endcase
            end
            run_string($urandom_range(0, 16), 30, 1'b0, 1'b0);
            phase++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_plain_chars();
        test_conversions();
        test_percent_cases();
        test_length_limit();
        test_random_strings();
        wait_idle();
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
